// ===== rtl/core/msw_pkg.sv =====
// Shared constants, codes and types for the mid/side stereo widener.
// No dependencies; imported by the widener top level, the norm divider and the checker.
package msw_pkg;

   // Sample format (signed Q1.15 at the default)
   localparam int SampleBits = 16;
   localparam int SampleMax  = 2 ** (SampleBits - 1) - 1;
   localparam int SampleMin  = -(2 ** (SampleBits - 1));

   // Delay lines
   localparam int DelayDepthDefault = 2048;
   localparam int DelayBits         = 11;

   // Width control, Q8
   localparam int WidthBits = 9;
   localparam int WidthMax  = 256;

   // Register port
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 11;

   localparam logic [CsrIndexBits-1:0] RegEnable        = 3'd0;
   localparam logic [CsrIndexBits-1:0] RegWidth         = 3'd1;
   localparam logic [CsrIndexBits-1:0] RegDelayMidLeft  = 3'd2;
   localparam logic [CsrIndexBits-1:0] RegDelayMidRight = 3'd3;
   localparam logic [CsrIndexBits-1:0] RegDelaySide     = 3'd4;

   // Mid term weight is 2^MidShift (Q9 accumulator)
   localparam int MidShift = 9;

   // Normalization: norm = round(2^NormFrac / (DenBase + 5w))
   localparam int DenBits   = 11;
   localparam int DenBase   = 512;
   localparam int NormFrac  = 25;
   localparam int NormBits  = 17;
   localparam int NormReset = ((1 << NormFrac) + DenBase / 2) / DenBase;

   typedef logic signed [SampleBits-1:0] sample_type;

   typedef struct packed {
      logic               start;
      logic [DenBits-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic [NormBits-1:0] norm;
   } div_rsp_type;

endpackage

// ===== rtl/core/msw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the mid and side delay lines.
module msw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/msw_norm_div.sv =====
// Restoring divider for the output normalization factor, one quotient bit per cycle.
// Depends on msw_pkg (widths, reset norm, request/response structs).
module msw_norm_div (
   input  logic                clock,
   input  logic                reset,
   input  msw_pkg::div_req_type req,
   output msw_pkg::div_rsp_type rsp
);
   import msw_pkg::*;

   localparam int NumBits = NormFrac + 1;
   localparam int CntBits = $clog2(NumBits + 1);

   logic                busy_ff, busy_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [NormBits-1:0] norm_ff, norm_in;
   logic [NumBits-1:0]  num_ff, num_in;
   logic [DenBits-1:0]  rem_ff, rem_in;
   logic [DenBits-1:0]  den_ff, den_in;
   logic [NormBits-1:0] quo_ff, quo_in;

   logic [DenBits:0]    trial;
   logic [DenBits:0]    diff;
   logic                ge;

   // one restoring step: bring down the next numerator bit
   assign trial = {rem_ff, num_ff[NumBits-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      norm_in = norm_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         // numerator carries the rounding term den/2
         busy_in = 1'b1;
         cnt_in  = CntBits'(NumBits);
         num_in  = (NumBits'(1) << NormFrac) + NumBits'(req.den >> 1);
         rem_in  = '0;
         den_in  = req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DenBits-1:0] : trial[DenBits-1:0];
         num_in = {num_ff[NumBits-2:0], 1'b0};
         quo_in = {quo_ff[NormBits-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            norm_in = {quo_ff[NormBits-2:0], ge};
         end
      end
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         norm_ff <= NormBits'(NormReset);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         norm_ff <= norm_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.norm = norm_ff;

endmodule

// ===== rtl/core/mid_side_delay_stereo_widener_top.sv =====
// Mid/side stereo widener with Haas delays: top level, control sequencer and serial datapath.
// Depends on msw_pkg, msw_ram (delay lines) and msw_norm_div (normalization divider).
//
// Each accepted stereo frame is split into mid and side, written into two delay lines, and
// rebuilt as side*(1+1.5w) + w*delayed side + 2w*(delayed mid L - delayed mid R) around mid,
// scaled by 1/(1+2.5w) and saturated. One frame is in work at a time: a processed frame goes
// through the delay-line reads (both mid taps over a single RAM read port), a 9-step
// bit-serial multiply by width, a 17-step bit-serial multiply by the norm factor, then
// saturation and the output register, before the next frame is accepted. With enable low a
// frame skips the processing and the delay lines are left untouched. A write to the width
// register starts a divide for the norm factor; frames and register writes are held off
// until it is done. Delay lines come up as zeros after reset without a clearing pass:
// entries not yet written since reset read as zero. The output register lets a new frame
// be accepted while a result still waits to be taken.
module mid_side_delay_stereo_widener_top #(
   parameter int DELAY_DEPTH = msw_pkg::DelayDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   // frame input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  msw_pkg::sample_type                req_left_in,
   input  msw_pkg::sample_type                req_right_in,
   // frame output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output msw_pkg::sample_type                rsp_left_out,
   output msw_pkg::sample_type                rsp_right_out,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msw_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [msw_pkg::CsrDataBits-1:0]    csr_wdata
);
   import msw_pkg::*;

   // datapath widths
   localparam int MsW        = SampleBits + 1;
   localparam int TW         = SampleBits + 4;
   localparam int P2W        = TW + 1;
   localparam int AccW       = P2W + WidthBits;
   localparam int ProdW      = AccW + 1;
   localparam int RoundShift = NormFrac - NormBits;
   localparam int QW         = ProdW - RoundShift;
   localparam int CntBits    = $clog2(NormBits + 1);

   // delay line addressing
   localparam int AddrBits = $clog2(DELAY_DEPTH);
   localparam int CalcBits = ((AddrBits > DelayBits) ? AddrBits : DelayBits) + 1;
   localparam logic [CalcBits-1:0] LastTap = CalcBits'(DELAY_DEPTH - 1);
   localparam logic [CalcBits-1:0] DepthC  = CalcBits'(DELAY_DEPTH);

   localparam logic signed [QW-1:0] QHi = QW'(SampleMax);
   localparam logic signed [QW-1:0] QLo = QW'(SampleMin);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD1  = 4'd1;
   localparam logic [3:0] S_RD2  = 4'd2;
   localparam logic [3:0] S_TSUM = 4'd3;
   localparam logic [3:0] S_MULW = 4'd4;
   localparam logic [3:0] S_ACC  = 4'd5;
   localparam logic [3:0] S_MULN = 4'd6;
   localparam logic [3:0] S_SAT  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   // tap address: entry written d frames ago, d clamped to the line length minus one
   function automatic logic [AddrBits-1:0] tap_addr(input logic [AddrBits-1:0]  wp,
                                                    input logic [DelayBits-1:0] d);
      logic [CalcBits-1:0] dc;
      logic [CalcBits-1:0] wc;
      logic [CalcBits-1:0] ix;
      dc = CalcBits'(d);
      if (dc > LastTap) begin
         dc = LastTap;
      end
      wc = CalcBits'(wp);
      if (wc >= dc) begin
         ix = wc - dc;
      end else begin
         ix = wc + DepthC - dc;
      end
      return ix[AddrBits-1:0];
   endfunction

   function automatic sample_type saturate(input logic signed [QW-1:0] q);
      logic signed [QW-1:0] c;
      c = q;
      if (q > QHi) begin
         c = QHi;
      end else if (q < QLo) begin
         c = QLo;
      end
      return c[SampleBits-1:0];
   endfunction

   // control registers
   logic [3:0]          state_ff, state_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AddrBits-1:0] wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic                enable_ff, enable_in;
   logic [WidthBits-1:0] weff_ff, weff_in;
   logic [DelayBits-1:0] delay_ml_ff, delay_ml_in;
   logic [DelayBits-1:0] delay_mr_ff, delay_mr_in;
   logic [DelayBits-1:0] delay_s_ff, delay_s_in;

   // payload registers
   sample_type                 mid_ff, mid_in;
   sample_type                 side_ff, side_in;
   sample_type                 dml_ff, dml_in;
   sample_type                 ds_ff, ds_in;
   logic                       ok_ml_ff, ok_ml_in;
   logic                       ok_s_ff, ok_s_in;
   logic                       ok_mr_ff, ok_mr_in;
   logic signed [TW-1:0]       t_ff, t_in;
   logic [WidthBits-1:0]       wsh_ff, wsh_in;
   logic signed [P2W-1:0]      p2_ff, p2_in;
   logic [WidthBits-1:0]       lo_ff, lo_in;
   logic signed [AccW-1:0]     acc_l_ff, acc_l_in;
   logic signed [AccW-1:0]     acc_r_ff, acc_r_in;
   logic [NormBits-1:0]        nsh_ff, nsh_in;
   logic signed [ProdW-1:0]    pl_ff, pl_in;
   logic signed [ProdW-1:0]    pr_ff, pr_in;
   sample_type                 res_l_ff, res_l_in;
   sample_type                 res_r_ff, res_r_in;
   sample_type                 rsp_l_ff, rsp_l_in;
   sample_type                 rsp_r_ff, rsp_r_in;

   // datapath nets
   logic                    req_fire;
   logic                    csr_fire;
   logic signed [MsW-1:0]   sum_lr;
   logic signed [MsW-1:0]   dif_lr;
   sample_type              mid_new;
   sample_type              side_new;
   logic [AddrBits-1:0]     addr_ml;
   logic [AddrBits-1:0]     addr_mr;
   logic [AddrBits-1:0]     addr_s;
   logic [AddrBits-1:0]     mid_raddr;
   logic                    line_we;
   sample_type              mid_rdata;
   sample_type              side_rdata;
   sample_type              dmr;
   logic signed [TW-1:0]    s_x;
   logic signed [TW-1:0]    ds_x;
   logic signed [TW-1:0]    dml_x;
   logic signed [TW-1:0]    dmr_x;
   logic signed [TW-1:0]    t_calc;
   logic signed [P2W-1:0]   p2_add;
   logic signed [P2W-1:0]   p2_sum;
   logic signed [AccW-1:0]  wt;
   logic signed [MsW-1:0]   ms_p;
   logic signed [MsW-1:0]   ms_m;
   logic signed [ProdW-1:0] pl_add;
   logic signed [ProdW-1:0] pr_add;
   logic signed [ProdW-1:0] pl_sum;
   logic signed [ProdW-1:0] pr_sum;
   logic signed [QW-1:0]    ql;
   logic signed [QW-1:0]    qr;
   logic [WidthBits-1:0]    w_raw;
   logic [WidthBits-1:0]    w_clamp;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   // handshakes
   assign req_stall = (state_ff != S_IDLE) || div_rsp.busy;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = !div_rsp.busy;
   assign csr_fire  = csr_valid && csr_ready;

   // mid and side of the incoming frame, floor halves
   assign sum_lr   = MsW'(req_left_in) + MsW'(req_right_in);
   assign dif_lr   = MsW'(req_left_in) - MsW'(req_right_in);
   assign mid_new  = sum_lr[SampleBits:1];
   assign side_new = dif_lr[SampleBits:1];

   // delay line taps
   assign addr_ml   = tap_addr(wp_ff, delay_ml_ff);
   assign addr_mr   = tap_addr(wp_ff, delay_mr_ff);
   assign addr_s    = tap_addr(wp_ff, delay_s_ff);
   assign mid_raddr = (state_ff == S_RD2) ? addr_mr : addr_ml;
   assign line_we   = req_fire && enable_ff;

   msw_ram #(
      .WIDTH (SampleBits),
      .DEPTH (DELAY_DEPTH)
   ) u_mid_line (
      .clock (clock),
      .we    (line_we),
      .waddr (wp_ff),
      .wdata (mid_new),
      .raddr (mid_raddr),
      .rdata (mid_rdata)
   );

   msw_ram #(
      .WIDTH (SampleBits),
      .DEPTH (DELAY_DEPTH)
   ) u_side_line (
      .clock (clock),
      .we    (line_we),
      .waddr (wp_ff),
      .wdata (side_new),
      .raddr (addr_s),
      .rdata (side_rdata)
   );

   // width write: clamp to full width, kick off the norm divide
   assign w_raw   = csr_wdata[WidthBits-1:0];
   assign w_clamp = (w_raw > WidthBits'(WidthMax)) ? WidthBits'(WidthMax) : w_raw;
   assign div_req.start = csr_fire && (csr_index == RegWidth);
   assign div_req.den   = DenBits'(DenBase) + (DenBits'(w_clamp) << 2) + DenBits'(w_clamp);

   msw_norm_div u_norm_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // t = 3*side + 2*dside + 4*(dmidL - dmidR)
   assign dmr    = ok_mr_ff ? mid_rdata : '0;
   assign s_x    = TW'(side_ff);
   assign ds_x   = TW'(ds_ff);
   assign dml_x  = TW'(dml_ff);
   assign dmr_x  = TW'(dmr);
   assign t_calc = (s_x <<< 1) + s_x + (ds_x <<< 1) + ((dml_x - dmr_x) <<< 2);

   // serial-parallel multiply t * w, width bits LSB first
   assign p2_add = wsh_ff[0] ? P2W'(t_ff) : '0;
   assign p2_sum = p2_ff + p2_add;

   // accumulators: 512*(mid +/- side) +/- w*t
   assign wt   = {p2_ff, lo_ff};
   assign ms_p = MsW'(mid_ff) + MsW'(side_ff);
   assign ms_m = MsW'(mid_ff) - MsW'(side_ff);

   // serial-parallel multiply acc * norm, low product bits dropped as they shift out
   assign pl_add = nsh_ff[0] ? ProdW'(acc_l_ff) : '0;
   assign pr_add = nsh_ff[0] ? ProdW'(acc_r_ff) : '0;
   assign pl_sum = pl_ff + pl_add;
   assign pr_sum = pr_ff + pr_add;

   // round half up at the remaining shift
   assign ql = QW'(pl_ff >>> RoundShift) + QW'(pl_ff[RoundShift-1]);
   assign qr = QW'(pr_ff >>> RoundShift) + QW'(pr_ff[RoundShift-1]);

   // configuration registers
   always_comb begin
      enable_in   = enable_ff;
      weff_in     = weff_ff;
      delay_ml_in = delay_ml_ff;
      delay_mr_in = delay_mr_ff;
      delay_s_in  = delay_s_ff;
      if (csr_fire) begin
         unique case (csr_index)
            RegEnable:        enable_in   = csr_wdata[0];
            RegWidth:         weff_in     = w_clamp;
            RegDelayMidLeft:  delay_ml_in = csr_wdata[DelayBits-1:0];
            RegDelayMidRight: delay_mr_in = csr_wdata[DelayBits-1:0];
            RegDelaySide:     delay_s_in  = csr_wdata[DelayBits-1:0];
            default:          enable_in   = enable_ff;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      mid_in       = mid_ff;
      side_in      = side_ff;
      dml_in       = dml_ff;
      ds_in        = ds_ff;
      ok_ml_in     = ok_ml_ff;
      ok_s_in      = ok_s_ff;
      ok_mr_in     = ok_mr_ff;
      t_in         = t_ff;
      wsh_in       = wsh_ff;
      p2_in        = p2_ff;
      lo_in        = lo_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      nsh_in       = nsh_ff;
      pl_in        = pl_ff;
      pr_in        = pr_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;

      // output register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (enable_ff) begin
                  mid_in   = mid_new;
                  side_in  = side_new;
                  state_in = S_RD1;
               end else begin
                  res_l_in = req_left_in;
                  res_r_in = req_right_in;
                  state_in = S_OUT;
               end
            end
         end
         S_RD1: begin
            // entries not written since reset read as zero
            ok_ml_in = wrapped_ff || (addr_ml <= wp_ff);
            ok_s_in  = wrapped_ff || (addr_s <= wp_ff);
            state_in = S_RD2;
         end
         S_RD2: begin
            dml_in   = ok_ml_ff ? mid_rdata : '0;
            ds_in    = ok_s_ff ? side_rdata : '0;
            ok_mr_in = wrapped_ff || (addr_mr <= wp_ff);
            state_in = S_TSUM;
         end
         S_TSUM: begin
            t_in   = t_calc;
            wsh_in = weff_ff;
            p2_in  = '0;
            lo_in  = '0;
            cnt_in = CntBits'(WidthBits);
            if (wp_ff == LastTap[AddrBits-1:0]) begin
               wp_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
            state_in = S_MULW;
         end
         S_MULW: begin
            p2_in  = p2_sum >>> 1;
            lo_in  = {p2_sum[0], lo_ff[WidthBits-1:1]};
            wsh_in = wsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_l_in = (AccW'(ms_p) <<< MidShift) + wt;
            acc_r_in = (AccW'(ms_m) <<< MidShift) - wt;
            nsh_in   = div_rsp.norm;
            pl_in    = '0;
            pr_in    = '0;
            cnt_in   = CntBits'(NormBits);
            state_in = S_MULN;
         end
         S_MULN: begin
            pl_in  = pl_sum >>> 1;
            pr_in  = pr_sum >>> 1;
            nsh_in = nsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            res_l_in = saturate(ql);
            res_r_in = saturate(qr);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         enable_ff    <= 1'b0;
         weff_ff      <= '0;
         delay_ml_ff  <= DelayBits'(1);
         delay_mr_ff  <= DelayBits'(1);
         delay_s_ff   <= DelayBits'(1);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         enable_ff    <= enable_in;
         weff_ff      <= weff_in;
         delay_ml_ff  <= delay_ml_in;
         delay_mr_ff  <= delay_mr_in;
         delay_s_ff   <= delay_s_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mid_ff   <= mid_in;
      side_ff  <= side_in;
      dml_ff   <= dml_in;
      ds_ff    <= ds_in;
      ok_ml_ff <= ok_ml_in;
      ok_s_ff  <= ok_s_in;
      ok_mr_ff <= ok_mr_in;
      t_ff     <= t_in;
      wsh_ff   <= wsh_in;
      p2_ff    <= p2_in;
      lo_ff    <= lo_in;
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
      nsh_ff   <= nsh_in;
      pl_ff    <= pl_in;
      pr_ff    <= pr_in;
      res_l_ff <= res_l_in;
      res_r_ff <= res_r_in;
      rsp_l_ff <= rsp_l_in;
      rsp_r_ff <= rsp_r_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

endmodule

// ===== rtl/core/msw_checker.sv =====
// Port-level checker for the stereo widener top level, attached by bind.
// Depends on msw_pkg (register index codes, sample type).
module msw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input msw_pkg::sample_type              rsp_left_out,
   input msw_pkg::sample_type              rsp_right_out,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [msw_pkg::CsrIndexBits-1:0] csr_index
);
   import msw_pkg::*;

   logic       in_fire;
   logic       out_fire;
   logic [1:0] pending_ff, pending_in;

   assign in_fire  = req_valid && !req_stall;
   assign out_fire = rsp_valid && !rsp_stall;

   // frames accepted and not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (in_fire && !out_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (out_fire && !in_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // one frame in work: input holds off right after a transfer
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> req_stall)
      else $error("frame accepted while previous frame still in work");

   // no result without a frame behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      out_fire |-> (pending_ff != 2'd0))
      else $error("result delivered with no frame outstanding");

   // at most one frame in work plus one result waiting
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many frames outstanding");

   // width write blocks frames and writes while the norm factor is rebuilt
   a_norm_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == RegWidth)) |=> (!csr_ready && req_stall))
      else $error("width write did not hold off traffic");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("stalled result changed");

endmodule

bind mid_side_delay_stereo_widener_top msw_checker u_msw_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for mid_side_delay_stereo_widener_top: directed table, random phases.
// Depends on msw_pkg and the widener RTL; holds its own bit-true model of the widener.
`timescale 1ns / 100ps

module tb;
   import msw_pkg::*;

   localparam int      Depth       = DelayDepthDefault;
   localparam int      DelayMax    = Depth - 1;
   localparam longint  MidWeight   = longint'(1) << MidShift;
   localparam longint  RoundHalf   = longint'(1) << (NormFrac - 1);
   localparam int      LongHold    = 300;
   localparam int      DrainCycles = 40;
   localparam int      RandPhases  = 10;
   localparam int      PhaseFrames = 40;

   // register indexes with no register behind them
   localparam logic [CsrIndexBits-1:0] RegUnusedLow  = 3'd5;
   localparam logic [CsrIndexBits-1:0] RegUnusedHigh = 3'd7;

   localparam sample_type Hi = 16'sh7fff;
   localparam sample_type Lo = 16'sh8000;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

   typedef struct packed {
      bit                      is_reg;
      logic [CsrIndexBits-1:0] reg_index;
      logic [CsrDataBits-1:0]  reg_data;
      sample_type              left;
      sample_type              right;
      bit                      typed;
      sample_type              exp_left;
      sample_type              exp_right;
   } row_type;

   // DUT interface
   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   sample_type              req_left_in   = '0;
   sample_type              req_right_in  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   sample_type              rsp_left_out;
   sample_type              rsp_right_out;
   logic                    csr_valid     = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index     = '0;
   logic [CsrDataBits-1:0]  csr_wdata     = '0;

   // model state
   sample_type        mid_line  [Depth];
   sample_type        side_line [Depth];
   logic [DelayBits-1:0] wr_pos   = '0;
   logic              cfg_enable  = 1'b0;
   logic [WidthBits-1:0] cfg_width = '0;
   logic [DelayBits-1:0] cfg_dly_mid_l = 11'd1;
   logic [DelayBits-1:0] cfg_dly_mid_r = 11'd1;
   logic [DelayBits-1:0] cfg_dly_side  = 11'd1;
   longint            norm_q16;

   frame_type pending_frames [$];
   row_type   directed_rows [$];
   int     mismatch_count = 0;
   int     frames_sent    = 0;
   int     frames_checked = 0;
   int     reg_writes     = 0;

   // idling controls: the first two are set by the main sequence, the counters belong to the output side
   bit long_hold_req = 1'b0;
   bit no_gaps       = 1'b0;
   int hold_left     = 0;
   int run_left      = 0;

   mid_side_delay_stereo_widener_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic longint norm_for_width(input logic [WidthBits-1:0] w);
      longint den;
      den = DenBase + 5 * longint'((w > WidthMax) ? WidthMax : w);
      return ((longint'(1) << NormFrac) + den / 2) / den;
   endfunction

   function automatic longint tap_line(input bit from_side, input logic [DelayBits-1:0] d);
      int dd;
      int idx;
      dd  = (d > DelayMax) ? DelayMax : int'(d);
      idx = (int'(wr_pos) + Depth - dd) % Depth;
      return from_side ? longint'(side_line[idx]) : longint'(mid_line[idx]);
   endfunction

   // scale by the norm factor, round half up, clamp to the sample range
   function automatic sample_type scale_sat(input longint acc);
      longint q;
      q = (acc * norm_q16 + RoundHalf) >>> NormFrac;
      if (q > SampleMax) q = SampleMax;
      if (q < SampleMin) q = SampleMin;
      return sample_type'(q);
   endfunction

   function automatic frame_type widen_frame(input sample_type l_in, input sample_type r_in);
      frame_type res;
      longint l, r, mid, side, dml, dmr, ds, w, acc_side;
      l = l_in;
      r = r_in;
      if (!cfg_enable) begin
         res.left  = l_in;
         res.right = r_in;
         return res;
      end
      mid  = (l + r) >>> 1;
      side = (l - r) >>> 1;
      mid_line[wr_pos]  = sample_type'(mid);
      side_line[wr_pos] = sample_type'(side);
      dml = tap_line(1'b0, cfg_dly_mid_l);
      dmr = tap_line(1'b0, cfg_dly_mid_r);
      ds  = tap_line(1'b1, cfg_dly_side);
      wr_pos = wr_pos + 1'b1;
      w = (cfg_width > WidthMax) ? WidthMax : cfg_width;
      acc_side = (MidWeight + 3 * w) * side + 2 * w * ds + 4 * w * (dml - dmr);
      res.left  = scale_sat(MidWeight * mid + acc_side);
      res.right = scale_sat(MidWeight * mid - acc_side);
      return res;
   endfunction

   function automatic void apply_register(input logic [CsrIndexBits-1:0] idx,
                                          input logic [CsrDataBits-1:0] data);
      case (idx)
         RegEnable: begin
            cfg_enable = data[0];
         end
         RegWidth: begin
            cfg_width = data[WidthBits-1:0];
            norm_q16  = norm_for_width(cfg_width);
         end
         RegDelayMidLeft:  cfg_dly_mid_l = data[DelayBits-1:0];
         RegDelayMidRight: cfg_dly_mid_r = data[DelayBits-1:0];
         RegDelaySide:     cfg_dly_side  = data[DelayBits-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- table rows
   function automatic row_type reg_row(input logic [CsrIndexBits-1:0] idx,
                                       input logic [CsrDataBits-1:0] data);
      row_type x;
      x = '0;
      x.is_reg    = 1'b1;
      x.reg_index = idx;
      x.reg_data  = data;
      return x;
   endfunction

   function automatic row_type frame_row(input int l, input int r);
      row_type x;
      x = '0;
      x.left  = sample_type'(l);
      x.right = sample_type'(r);
      return x;
   endfunction

   function automatic row_type known_row(input int l, input int r, input int el, input int er);
      row_type x;
      x = frame_row(l, r);
      x.typed     = 1'b1;
      x.exp_left  = sample_type'(el);
      x.exp_right = sample_type'(er);
      return x;
   endfunction

   // ---------------------------------------------------------------- random picks
   // mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(12, 50);
   endfunction

   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return Hi;
         1: return Lo;
         2: return sample_type'($urandom_range(0, 16) - 8);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [CsrDataBits-1:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return CsrDataBits'($urandom_range(0, 24));
      if (roll < 85) return CsrDataBits'(DelayMax);
      return CsrDataBits'($urandom_range(0, DelayMax));
   endfunction

   function automatic logic [CsrDataBits-1:0] pick_width();
      logic [CsrDataBits-1:0] raw;
      raw = CsrDataBits'($urandom);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return CsrDataBits'(WidthMax);
         2: return {raw[CsrDataBits-1:WidthBits], {WidthBits{1'b1}}};
         default: return raw;
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers
   // register write: only with the pipeline empty; valid stays up between back-to-back writes
   task automatic write_register(input logic [CsrIndexBits-1:0] idx,
                                 input logic [CsrDataBits-1:0] data);
      logic taken;
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      apply_register(idx, data);
      reg_writes++;
   endtask

   // one frame transfer; the model runs at the accepting edge
   task automatic send_frame(input sample_type l, input sample_type r, input bit typed,
                             input sample_type el, input sample_type er);
      int        gap;
      logic      taken;
      frame_type due;
      gap = pick_gap();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      due = widen_frame(l, r);
      if (typed) begin
         due.left  = el;
         due.right = er;
      end
      pending_frames.push_back(due);
      frames_sent++;
   endtask

   // output side stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_req) begin
            hold_left     = LongHold;
            long_hold_req = 1'b0;
         end else if (hold_left == 0 && run_left <= 0) begin
            run_left  = no_gaps ? 1 : $urandom_range(1, 16);
            hold_left = pick_gap();
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left--;
         end
      end
   end

   // result check, sampled half a cycle ahead of the accepting edge
   always @(negedge clock) begin
      frame_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result, got left %0d right %0d",
                     $time, rsp_left_out, rsp_right_out);
         end else begin
            due = pending_frames.pop_front();
            frames_checked++;
            if (rsp_left_out !== due.left) begin
               mismatch_count++;
               $display("%0t: left_out expected %0d got %0d",
                        $time, due.left, rsp_left_out);
            end
            if (rsp_right_out !== due.right) begin
               mismatch_count++;
               $display("%0t: right_out expected %0d got %0d",
                        $time, due.right, rsp_right_out);
            end
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      for (int i = 0; i < Depth; i++) begin
         mid_line[i]  = '0;
         side_line[i] = '0;
      end
      norm_q16 = norm_for_width('0);

      directed_rows = {
         // disabled after reset: straight pass-through
         known_row(Hi, Lo, Hi, Lo),
         known_row(Lo, Hi, Lo, Hi),
         known_row(0, -1, 0, -1),
         // zero side delay, width zero: pure mid/side round trip
         reg_row(RegDelaySide, 11'd0),
         reg_row(RegEnable, 11'd1),
         known_row(0, 0, 0, 0),
         known_row(100, -100, 100, -100),
         frame_row(Hi, Hi),
         // full width, saturating extremes
         reg_row(RegWidth, CsrDataBits'(WidthMax)),
         frame_row(Hi, Lo),
         frame_row(Lo, Hi),
         frame_row(Lo, Lo),
         frame_row(Hi, Hi),
         // width above full acts as full
         reg_row(RegWidth, 11'd511),
         frame_row(Lo, Hi),
         frame_row(Hi, Lo),
         // longest and zero mid taps
         reg_row(RegDelayMidLeft, CsrDataBits'(DelayMax)),
         reg_row(RegDelayMidRight, 11'd0),
         frame_row(Hi, Lo),
         frame_row(-1, 0),
         frame_row(Lo, Lo),
         reg_row(RegDelaySide, CsrDataBits'(DelayMax)),
         // writes to unused indexes change nothing
         reg_row(RegUnusedLow, 11'h7ff),
         reg_row(RegUnusedHigh, 11'd0),
         frame_row(12345, -23456),
         // back to pass-through, then enable with upper data bits set
         reg_row(RegEnable, 11'd0),
         known_row(-7, 9, -7, 9),
         reg_row(RegEnable, 11'h7ff),
         reg_row(RegWidth, 11'h7ff),
         frame_row(1, -1),
         reg_row(RegWidth, 11'd128),
         reg_row(RegDelayMidLeft, 11'd1),
         reg_row(RegDelayMidRight, 11'd3),
         reg_row(RegDelaySide, 11'd2),
         frame_row(20000, -20000),
         frame_row(-15000, 31000),
         frame_row(7, 8),
         frame_row(Lo, 0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_reg)
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
         else
            send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed,
                       directed_rows[i].exp_left, directed_rows[i].exp_right);
      end

      // random phases: new settings, then a burst of frames
      for (int phase = 0; phase < RandPhases; phase++) begin
         write_register(RegEnable, {(CsrDataBits - 1)'($urandom), (phase % 5) != 3});
         write_register(RegWidth, pick_width());
         write_register(RegDelayMidLeft, pick_delay());
         write_register(RegDelayMidRight, pick_delay());
         write_register(RegDelaySide, pick_delay());
         no_gaps = (phase == 4);
         if (phase == 2) long_hold_req = 1'b1;
         for (int n = 0; n < PhaseFrames; n++)
            send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d frames, checked %0d, %0d register writes over %0d random phases",
               frames_sent, frames_checked, reg_writes, RandPhases);
      $display("Covered pass-through, widths 0..511, tap delays 0..%0d, one long output hold",
               DelayMax);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
